// ----- hw/rtl/four_channel_servo_slew_controller_assert.svh -----
// Assertion macros for the servo slew controller RTL.
`ifndef FOUR_CHANNEL_SERVO_SLEW_CONTROLLER_ASSERT_SVH
`define FOUR_CHANNEL_SERVO_SLEW_CONTROLLER_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define FCSSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FCSSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fcssc_pkg.sv -----
// Shared types, constants and register codes of the servo slew controller.
package fcssc_pkg;

    localparam int CHANNELS       = 4;
    localparam int ANGLE_W        = 9;
    localparam int WIDTH_W        = 12;
    localparam int NUM_W          = 17;
    localparam int QUO_W          = 13;
    localparam int RECIP_W        = 16;
    localparam int PROD_W         = 32;
    localparam int CFG_W          = 8;
    localparam int OUT_COUNT_W    = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [CFG_W-1:0] STEP_SIZE_RESET     = 8'd25;
    localparam logic [CFG_W-1:0] STATUS_PERIOD_RESET = 8'd25;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic        [WIDTH_W-1:0] t_width;
    typedef logic signed [NUM_W-1:0]   t_num;

    // Angle to pulse width: (slope * angle + offset) / divisor, truncated.
    localparam t_num MAP_SLOPE [CHANNELS] = '{17'sd35, -17'sd100, 17'sd100, -17'sd100};
    localparam t_num MAP_OFFSET [CHANNELS] = '{17'sd1500, 17'sd21600, 17'sd12600, 17'sd15300};

    // Division by 3 or 9 as a multiply by a rounded-up reciprocal and a shift.
    // Exact for every non-negative numerator below 2^16.
    localparam logic [RECIP_W-1:0] RECIP [CHANNELS] = '{16'd43691, 16'd58255, 16'd58255,
                                                         16'd58255};
    localparam int RECIP_SHIFT [CHANNELS] = '{17, 19, 19, 19};

    localparam logic [QUO_W-1:0] LIM_LO [CHANNELS] = '{13'd500, 13'd1400, 13'd1400, 13'd700};
    localparam logic [QUO_W-1:0] LIM_HI [CHANNELS] = '{13'd2600, 13'd2400, 13'd2400, 13'd1700};

    localparam t_width HOME_WIDTH [CHANNELS] = '{12'd1550, 12'd1400, 12'd2400, 12'd700};

    typedef enum logic {
        REG_STEP_SIZE     = 1'b0,
        REG_STATUS_PERIOD = 1'b1
    } t_reg_idx;

    // A classified command as it travels from the front end to the back end.
    typedef struct packed {
        t_width [CHANNELS-1:0] mapped;
        logic                  ok;
        logic                  sentinel;
    } t_cmd;

    typedef struct packed {
        t_width [CHANNELS-1:0]  width;
        logic                   moving;
        logic                   viable;
        logic                   done;
        logic                   snap;
        logic [OUT_COUNT_W-1:0] accepted;
        logic [OUT_COUNT_W-1:0] rejected;
    } t_result;

endpackage

// ----- hw/rtl/four_channel_servo_slew_controller.sv -----
// Top level of the four-channel servo slew controller.
//
// Each request on the input channel carries four joint angles (i_angle_a..d).
// While the controller is idle, a request is a command: the angles are mapped
// to pulse widths and checked against the joint limits. A command inside all
// limits starts a move; one outside is counted as rejected, and one with any
// angle of -1 is taken as "no command" and leaves everything alone. While a
// move runs, every request is one tick that slews each channel by step_size (by 1 when step_size is 0).
// Every request yields exactly one result request with the widths, flags and
// the saturating accept and reject counts after that request.
// The edge that accepts a request loads the numerator stage; the divide and limit
// outcome is then written into the two-entry command queue, and from there the
// back end loads the result register, whose valid rises with it. Throughput is
// one request per cycle while the receiver does not stall; the result register
// frees the back end as soon as the receiver takes its request.
// When the receiver stalls, the result holds, the queue fills and then
// o_in_stall rises. Reset empties the pipeline, homes the channels to
// 1550/1400/2400/700 us and sets both registers to 25.
module four_channel_servo_slew_controller #(
    parameter int COUNT_BITS = fcssc_pkg::DEF_COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [fcssc_pkg::ANGLE_W-1:0]       i_angle_a,
    input  logic [fcssc_pkg::ANGLE_W-1:0]       i_angle_b,
    input  logic [fcssc_pkg::ANGLE_W-1:0]       i_angle_c,
    input  logic [fcssc_pkg::ANGLE_W-1:0]       i_angle_d,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fcssc_pkg::WIDTH_W-1:0]       o_width_a,
    output logic [fcssc_pkg::WIDTH_W-1:0]       o_width_b,
    output logic [fcssc_pkg::WIDTH_W-1:0]       o_width_c,
    output logic [fcssc_pkg::WIDTH_W-1:0]       o_width_d,
    output logic                                o_moving,
    output logic                                o_last_viable,
    output logic                                o_move_done,
    output logic                                o_status_valid,
    output logic [fcssc_pkg::OUT_COUNT_W-1:0]   o_accepted_moves,
    output logic [fcssc_pkg::OUT_COUNT_W-1:0]   o_rejected_moves,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fcssc_pkg::PADDR_W-1:0]       paddr,
    input  logic [fcssc_pkg::PDATA_W-1:0]       pwdata,
    output logic [fcssc_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import fcssc_pkg::*;

    logic [CFG_W-1:0]          r_step_size;
    logic [CFG_W-1:0]          r_status_period;
    logic                      cfg_write;
    t_reg_idx                  cfg_idx;
    t_angle [CHANNELS-1:0]     angle;
    logic                      push;
    logic                      full;
    logic                      empty;
    logic                      pop;
    t_cmd                      front_cmd;
    t_cmd                      queue_cmd;
    t_result                   result;

    // Register map: step_size at byte 0, status_period at byte 4.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size     <= STEP_SIZE_RESET;
            r_status_period <= STATUS_PERIOD_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_STEP_SIZE: begin
                    r_step_size <= pwdata[CFG_W-1:0];
                end
                REG_STATUS_PERIOD: begin
                    r_status_period <= pwdata[CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STEP_SIZE: begin
                prdata = PDATA_W'(r_step_size);
            end
            REG_STATUS_PERIOD: begin
                prdata = PDATA_W'(r_status_period);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign angle[0] = i_angle_a;
    assign angle[1] = i_angle_b;
    assign angle[2] = i_angle_c;
    assign angle[3] = i_angle_d;

    // The front end classifies every request without knowing the move state;
    // the back end decides what a command or a tick does.
    fcssc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_angle    (angle),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    fcssc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (queue_cmd)
    );

    fcssc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (!empty),
        .o_cmd_pop       (pop),
        .i_cmd           (queue_cmd),
        .i_step_size     (r_step_size),
        .i_status_period (r_status_period),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result        (result)
    );

    assign o_width_a        = result.width[0];
    assign o_width_b        = result.width[1];
    assign o_width_c        = result.width[2];
    assign o_width_d        = result.width[3];
    assign o_moving         = result.moving;
    assign o_last_viable    = result.viable;
    assign o_move_done      = result.done;
    assign o_status_valid   = result.snap;
    assign o_accepted_moves = result.accepted;
    assign o_rejected_moves = result.rejected;

endmodule

// ----- hw/rtl/fcssc_front.sv -----
// Front end: takes requests, maps angles to widths and checks the joint limits.
module fcssc_front (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  fcssc_pkg::t_angle [fcssc_pkg::CHANNELS-1:0] i_angle,
    input  logic                                       i_full,
    output logic                                       o_push,
    output fcssc_pkg::t_cmd                            o_cmd
);
    import fcssc_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    t_num [CHANNELS-1:0]     r_num;
    t_num [CHANNELS-1:0]     n_num;
    logic                    r_sentinel;
    logic                    n_sentinel;
    logic                    accept;
    logic [PROD_W-1:0]       prod [CHANNELS];
    logic [QUO_W-1:0]        quo [CHANNELS];
    logic [CHANNELS-1:0]     in_lim;

    assign o_in_stall = r_valid && i_full;
    assign o_push     = r_valid && !i_full;
    assign accept     = i_in_valid && !o_in_stall;

    // First stage: numerators and the no-command mark.
    always_comb begin
        n_num      = r_num;
        n_sentinel = r_sentinel;
        if (accept) begin
            n_sentinel = 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                n_num[ch] = NUM_W'($signed(i_angle[ch]) * MAP_SLOPE[ch]) + MAP_OFFSET[ch];
                if (i_angle[ch] == '1) begin
                    n_sentinel = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    // Second stage: reciprocal divide and limit compare. A negative numerator
    // always fails the limit check, whatever width it truncates to.
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            prod[ch]   = PROD_W'(r_num[ch][RECIP_W-1:0]) * PROD_W'(RECIP[ch]);
            quo[ch]    = QUO_W'(prod[ch] >> RECIP_SHIFT[ch]);
            in_lim[ch] = !r_num[ch][NUM_W-1] && (quo[ch] >= LIM_LO[ch])
                         && (quo[ch] <= LIM_HI[ch]);
            o_cmd.mapped[ch] = quo[ch][WIDTH_W-1:0];
        end
        o_cmd.ok       = &in_lim;
        o_cmd.sentinel = r_sentinel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_sentinel <= n_sentinel;
    end

endmodule

// ----- hw/rtl/fcssc_fifo.sv -----
// Short command queue between the front end and the back end.
module fcssc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fcssc_pkg::t_cmd i_data,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output fcssc_pkg::t_cmd o_data
);
    import fcssc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push_ok) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/fcssc_back.sv -----
// Back end: move state, slew steps, counters and the result register.
`include "four_channel_servo_slew_controller_assert.svh"

module fcssc_back #(
    parameter int COUNT_BITS = fcssc_pkg::DEF_COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    input  fcssc_pkg::t_cmd               i_cmd,
    input  logic [fcssc_pkg::CFG_W-1:0]   i_step_size,
    input  logic [fcssc_pkg::CFG_W-1:0]   i_status_period,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fcssc_pkg::t_result            o_result
);
    import fcssc_pkg::*;

    t_width [CHANNELS-1:0]   r_target;
    t_width [CHANNELS-1:0]   n_target;
    t_width [CHANNELS-1:0]   r_current;
    t_width [CHANNELS-1:0]   n_current;
    logic [CHANNELS-1:0]     r_step_up;
    logic [CHANNELS-1:0]     n_step_up;
    logic                    r_busy;
    logic                    n_busy;
    logic                    r_viable;
    logic                    n_viable;
    logic [COUNT_BITS-1:0]   r_acc;
    logic [COUNT_BITS-1:0]   n_acc;
    logic [COUNT_BITS-1:0]   r_rej;
    logic [COUNT_BITS-1:0]   n_rej;
    logic [CFG_W-1:0]        r_period;
    logic [CFG_W-1:0]        n_period;
    logic [CFG_W-1:0]        period_inc;
    logic [CFG_W-1:0]        step;
    logic [WIDTH_W-1:0]      diff [CHANNELS];
    logic                    all_there;
    logic                    done;
    logic                    snap;
    logic                    fire;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_result                 r_result;
    t_result                 n_result;

    assign fire        = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_cmd_pop   = fire;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign step        = (i_step_size == '0) ? CFG_W'(1) : i_step_size;
    assign period_inc  = r_period + CFG_W'(1);

    always_comb begin
        n_target  = r_target;
        n_current = r_current;
        n_step_up = r_step_up;
        n_busy    = r_busy;
        n_viable  = r_viable;
        n_acc     = r_acc;
        n_rej     = r_rej;
        n_period  = r_period;
        all_there = 1'b1;
        done      = 1'b0;
        snap      = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            diff[ch] = (r_target[ch] > r_current[ch]) ? r_target[ch] - r_current[ch]
                                                      : r_current[ch] - r_target[ch];
        end
        if (fire) begin
            if (!r_busy) begin
                if (i_cmd.ok) begin
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        n_target[ch]  = i_cmd.mapped[ch];
                        n_step_up[ch] = i_cmd.mapped[ch] > r_current[ch];
                    end
                    n_busy   = 1'b1;
                    n_viable = 1'b1;
                    if (!(&r_acc)) begin
                        n_acc = r_acc + COUNT_BITS'(1);
                    end
                end else if (!i_cmd.sentinel) begin
                    n_viable = 1'b0;
                    if (!(&r_rej)) begin
                        n_rej = r_rej + COUNT_BITS'(1);
                    end
                end
            end else begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (diff[ch] <= WIDTH_W'(step)) begin
                        n_current[ch] = r_target[ch];
                    end else if (r_step_up[ch]) begin
                        n_current[ch] = r_current[ch] + WIDTH_W'(step);
                    end else begin
                        n_current[ch] = r_current[ch] - WIDTH_W'(step);
                    end
                    if (n_current[ch] != r_target[ch]) begin
                        all_there = 1'b0;
                    end
                end
                if (all_there) begin
                    n_busy = 1'b0;
                    done   = 1'b1;
                end
            end
            if (period_inc == i_status_period) begin
                snap     = 1'b1;
                n_period = '0;
            end else begin
                n_period = period_inc;
            end
        end
    end

    always_comb begin
        n_result.width    = n_current;
        n_result.moving   = n_busy;
        n_result.viable   = n_viable;
        n_result.done     = done;
        n_result.snap     = snap;
        n_result.accepted = OUT_COUNT_W'(n_acc);
        n_result.rejected = OUT_COUNT_W'(n_rej);
    end

    always_comb begin
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_current[ch] <= HOME_WIDTH[ch];
            end
            r_target    <= '0;
            r_step_up   <= '0;
            r_busy      <= 1'b0;
            r_viable    <= 1'b0;
            r_acc       <= '0;
            r_rej       <= '0;
            r_period    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_current   <= n_current;
            r_target    <= n_target;
            r_step_up   <= n_step_up;
            r_busy      <= n_busy;
            r_viable    <= n_viable;
            r_acc       <= n_acc;
            r_rej       <= n_rej;
            r_period    <= n_period;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    // A finished move leaves every channel on its target.
    `FCSSC_ASSERT(a_move_lands, fire && r_busy && !n_busy |=> (r_current == r_target), "move ended off target")
    // The moving flag of a held result always agrees with the move state.
    `FCSSC_ASSERT(a_moving_tracks, r_out_valid |-> (r_result.moving == r_busy), "moving flag out of step")
    // A completion pulse never comes with the moving flag still set.
    `FCSSC_ASSERT(a_done_idle, r_out_valid && r_result.done |-> !r_result.moving, "done while moving")
    // Ticks of a move never count as accepted commands.
    `FCSSC_ASSERT(a_tick_no_count, fire && r_busy |=> (r_acc == $past(r_acc)), "tick changed the accept count")
    // Reset leaves no result pending.
    `FCSSC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule
